// File: rtl/counting_semaphore_wait_queue_defines.svh
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csem: property failed");

// next-cycle implication, sampled on clk, off during reset
`define CSEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csem: property failed");

`endif

// File: rtl/csem_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: package
// Sizes, request and status codes, and payload types.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int TOT_W     = $clog2(MAX_TASKS + 1);
  localparam int ID_W      = 4;
  localparam int CNT_W     = 31;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  localparam logic REG_INIT = 1'b0;
  localparam logic REG_MAX  = 1'b1;

  typedef enum logic [2:0] {
    REQ_WAIT    = 3'd0,
    REQ_TRYWAIT = 3'd1,
    REQ_POST    = 3'd2,
    REQ_CLOSE   = 3'd3,
    REQ_CANCEL  = 3'd4,
    REQ_REINIT  = 3'd5
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_CLOSED      = 3'd2,
    ST_UNAVAIL     = 3'd3,
    ST_AT_LIMIT    = 3'd4,
    ST_ALREADY     = 3'd5,
    ST_NOT_WAITING = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [ID_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic             result_kind;
    logic [ID_W-1:0]  task_id_out;
    logic [2:0]       status;
    logic [CNT_W-1:0] count_now;
    logic [4:0]       waiters_now;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] reload_count;
    logic [CNT_W-1:0] count_cap;
  } cfg_t;

endpackage

// File: rtl/csem_regs.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: configuration registers
// APB-style register file holding the reload count and the count limit.
// ----------------------------------------------------------------------------
module csem_regs
  import csem_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reload_count <= '0;
      cfg.count_cap    <= CNT_TOP;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_INIT: cfg.reload_count <= pwdata[CNT_W-1:0];
        REG_MAX:  cfg.count_cap    <= pwdata[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INIT: prdata = DATA_W'(cfg.reload_count);
      REG_MAX:  prdata = DATA_W'(cfg.count_cap);
    endcase
  end

endmodule

// File: rtl/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue
// Counting semaphore with a FIFO of waiting tasks kept in a RAM with a registered read.
// ----------------------------------------------------------------------------
// Requests (req_type, task_id) enter on the req channel under valid/ready;
// results leave on the rsp channel. Each request yields zero or more wake
// notices, oldest waiter first, and then exactly one reply marked last.
// Configuration (reload count at 0x0, count cap at 0x4) goes through the
// APB-style port and is used by later requests.
// One request is in flight at a time: req_ready is high only in S_IDLE,
// which is re-entered once the reply is loaded. Every wake notice takes a
// queue RAM read (S_RD), then the output load (S_WK); cancel walks the
// queue entry by entry (a RAM read in S_CAN_RD, a compare in S_CAN_CK) up
// to the queue's tail.
// Reset empties the queue, clears the count and reopens the semaphore; no
// clearing pass is needed. A stalled rsp channel holds the output register
// and freezes the wake sequence until the result is taken.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
  import csem_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WK,
    S_CAN_RD,
    S_CAN_CK,
    S_REPLY
  } state_t;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= (IDX_W+1)'(MAX_TASKS)) s = s - (IDX_W+1)'(MAX_TASKS);
    return s[IDX_W-1:0];
  endfunction

  cfg_t cfg;

  logic [ID_W-1:0]  queue_mem [MAX_TASKS];
  logic [ID_W-1:0]  rd_data;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [ID_W-1:0]  wdata;
  logic             we;

  state_t           state;
  logic [CNT_W-1:0] sem_count;
  logic             closed;
  logic [MAX_TASKS-1:0] marks;
  logic [IDX_W-1:0] head;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] wake_left;
  logic [TOT_W-1:0] q;
  logic             found;
  logic             reinit_pend;
  logic [ID_W-1:0]  rep_id;
  logic [2:0]       rep_st;
  logic             rsp_valid_q;
  rsp_t             rsp_q;

  logic             out_free;
  logic             rsp_load;
  logic             id_ok;
  logic             id_marked;
  logic             at_limit;
  logic [CNT_W-1:0] init_sat;
  logic             enqueue;
  logic [IDX_W-1:0] head_inc;
  logic [TOT_W-1:0] q_dec;
  logic             hit;
  logic             last_pos;

  csem_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;
  assign out_free  = !rsp_valid_q || rsp_ready;
  assign rsp_load  = out_free && ((state == S_WK) || (state == S_REPLY));

  assign id_ok     = 32'(req.task_id) < MAX_TASKS;
  assign id_marked = marks[IDX_W'(req.task_id)];
  assign at_limit  = (sem_count == CNT_TOP) || (sem_count >= cfg.count_cap);
  assign init_sat  = (cfg.reload_count > cfg.count_cap) ? cfg.count_cap
                                                        : cfg.reload_count;
  assign head_inc  = (head == IDX_W'(MAX_TASKS - 1)) ? '0 : head + 1'b1;
  assign q_dec     = q - 1'b1;
  assign hit       = (rd_data == rep_id);
  assign last_pos  = ((q + 1'b1) == total);

  assign enqueue = req_valid && (state == S_IDLE) && (req.req_type == REQ_WAIT) &&
                   !closed && (sem_count == '0) && id_ok && !id_marked &&
                   (32'(total) < MAX_TASKS);

  always_comb begin
    unique case (state)
      S_CAN_RD, S_CAN_CK: raddr = slot(head, q[IDX_W-1:0]);
      default:            raddr = head;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot(head, total[IDX_W-1:0]);
    wdata = req.task_id;
    if (enqueue) begin
      we = 1'b1;
    end else if ((state == S_CAN_CK) && found) begin
      we    = 1'b1;
      waddr = slot(head, q_dec[IDX_W-1:0]);
      wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) queue_mem[waddr] <= wdata;
    rd_data <= queue_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sem_count   <= '0;
      closed      <= 1'b0;
      marks       <= '0;
      head        <= '0;
      total       <= '0;
      wake_left   <= '0;
      q           <= '0;
      found       <= 1'b0;
      reinit_pend <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            rep_id      <= req.task_id;
            reinit_pend <= 1'b0;
            state       <= S_REPLY;
            unique case (req.req_type)
              REQ_WAIT: begin
                if (closed) begin
                  rep_st <= ST_CLOSED;
                end else if (sem_count != '0) begin
                  sem_count <= sem_count - 1'b1;
                  rep_st    <= ST_OK;
                end else if (!id_ok) begin
                  rep_st <= ST_UNAVAIL;
                end else if (id_marked) begin
                  rep_st <= ST_ALREADY;
                end else if (32'(total) >= MAX_TASKS) begin
                  rep_st <= ST_UNAVAIL;
                end else begin
                  marks[IDX_W'(req.task_id)] <= 1'b1;
                  total  <= total + 1'b1;
                  rep_st <= ST_QUEUED;
                end
              end
              REQ_TRYWAIT: begin
                if (closed) begin
                  rep_st <= ST_CLOSED;
                end else if (sem_count != '0) begin
                  sem_count <= sem_count - 1'b1;
                  rep_st    <= ST_OK;
                end else begin
                  rep_st <= ST_UNAVAIL;
                end
              end
              REQ_POST: begin
                if (closed) begin
                  rep_st <= ST_CLOSED;
                end else if (at_limit) begin
                  rep_st <= ST_AT_LIMIT;
                end else begin
                  sem_count <= sem_count + 1'b1;
                  rep_st    <= ST_OK;
                  if (total != '0) begin
                    total     <= total - 1'b1;
                    wake_left <= TOT_W'(1);
                    state     <= S_RD;
                  end
                end
              end
              REQ_CLOSE: begin
                closed <= 1'b1;
                rep_st <= ST_OK;
                if (total != '0) begin
                  wake_left <= total;
                  total     <= '0;
                  state     <= S_RD;
                end
              end
              REQ_CANCEL: begin
                if (!id_ok || !id_marked) begin
                  rep_st <= ST_NOT_WAITING;
                end else begin
                  q     <= '0;
                  found <= 1'b0;
                  state <= S_CAN_RD;
                end
              end
              REQ_REINIT: begin
                sem_count <= init_sat;
                closed    <= 1'b0;
                rep_st    <= ST_OK;
                if (total != '0) begin
                  wake_left   <= total;
                  total       <= '0;
                  reinit_pend <= 1'b1;
                  state       <= S_RD;
                end else begin
                  head <= '0;
                end
              end
              default: rep_st <= ST_UNAVAIL;
            endcase
          end
        end
        S_RD: state <= S_WK;
        S_WK: begin
          if (out_free) begin
            rsp_q <= '{result_kind: KIND_WAKE, task_id_out: rd_data, status: ST_OK,
                       count_now: sem_count, waiters_now: 5'(total), last: 1'b0};
            marks[IDX_W'(rd_data)] <= 1'b0;
            wake_left <= wake_left - 1'b1;
            if (wake_left == TOT_W'(1)) begin
              head  <= reinit_pend ? '0 : head_inc;
              state <= S_REPLY;
            end else begin
              head  <= head_inc;
              state <= S_RD;
            end
          end
        end
        S_CAN_RD: state <= S_CAN_CK;
        S_CAN_CK: begin
          if (last_pos) begin
            marks[IDX_W'(rep_id)] <= 1'b0;
            if (found || hit) begin
              total  <= total - 1'b1;
              rep_st <= ST_OK;
            end else begin
              rep_st <= ST_NOT_WAITING;
            end
            state <= S_REPLY;
          end else begin
            found <= found || hit;
            q     <= q + 1'b1;
            state <= S_CAN_RD;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            rsp_q <= '{result_kind: KIND_REPLY, task_id_out: rep_id, status: rep_st,
                       count_now: sem_count, waiters_now: 5'(total), last: 1'b1};
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/csem_checker.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: port checker
// Concurrent checks on the top level's channels, bound to every instance.
// ----------------------------------------------------------------------------
`include "counting_semaphore_wait_queue_defines.svh"

module csem_checker
  import csem_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input rsp_t              rsp
);

  `CSEM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `CSEM_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
  `CSEM_ASSERT_NOW(a_wake_form, rsp_valid && (rsp.result_kind == KIND_WAKE),
                   !rsp.last && (rsp.status == ST_OK))
  `CSEM_ASSERT_NOW(a_last_is_reply, rsp_valid && rsp.last,
                   (rsp.result_kind == KIND_REPLY) && (rsp.waiters_now <= 5'd16))

endmodule

bind counting_semaphore_wait_queue csem_checker u_csem_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: testbench
// Sends wait, trywait, post, close, cancel, reinit, bad codes under random
// idling and configuration changes. Tracks the semaphore state in step with
// accepted requests and checks every wake notice and reply in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import csem_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE       = 8;
  localparam int IDLE_PCT     = 23;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [CNT_W-1:0]  load_count  = '0;
  logic [CNT_W-1:0]  count_limit = CNT_TOP;
  logic [CNT_W-1:0]  units       = '0;
  logic              shut        = 1'b0;
  logic [ID_W-1:0]   line_ids [MAX_TASKS];
  bit                queued_mark [MAX_TASKS];
  logic [IDX_W-1:0]  head        = '0;
  int                line_len    = 0;

  req_t pending_reqs[$];
  rsp_t awaited_results[$];
  int   queued_total   = 0;
  int   accepted_total = 0;
  int   real_items     = 0;
  int   mismatches     = 0;
  int   cycles         = 0;
  bit   steady         = 1'b0;

  always #5 clk = ~clk;

  counting_semaphore_wait_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic logic [ID_W-1:0] take_oldest();
    logic [ID_W-1:0] id;
    id = line_ids[head];
    queued_mark[id] = 1'b0;
    head = head + 1'b1;
    line_len = line_len - 1;
    return id;
  endfunction

  task automatic step_semaphore(input req_t r);
    logic [ID_W-1:0]  woken[$];
    logic [IDX_W-1:0] slot;
    rsp_t             item;
    status_e          st;
    int               p;
    int               n;
    st = ST_UNAVAIL;
    case (r.req_type)
      REQ_WAIT: begin
        if (shut) st = ST_CLOSED;
        else if (units != '0) begin
          units = units - 1'b1;
          st = ST_OK;
        end else if (queued_mark[r.task_id]) st = ST_ALREADY;
        else if (line_len >= MAX_TASKS) st = ST_UNAVAIL;
        else begin
          slot = head + IDX_W'(line_len);
          line_ids[slot] = r.task_id;
          queued_mark[r.task_id] = 1'b1;
          line_len = line_len + 1;
          st = ST_QUEUED;
        end
      end
      REQ_TRYWAIT: begin
        if (shut) st = ST_CLOSED;
        else if (units != '0) begin
          units = units - 1'b1;
          st = ST_OK;
        end else st = ST_UNAVAIL;
      end
      REQ_POST: begin
        if (shut) st = ST_CLOSED;
        else if (units == CNT_TOP || units >= count_limit) st = ST_AT_LIMIT;
        else begin
          units = units + 1'b1;
          if (line_len > 0) woken.push_back(take_oldest());
          st = ST_OK;
        end
      end
      REQ_CLOSE: begin
        shut = 1'b1;
        while (line_len > 0) woken.push_back(take_oldest());
        st = ST_OK;
      end
      REQ_CANCEL: begin
        st = ST_NOT_WAITING;
        if (queued_mark[r.task_id]) begin
          p = 0;
          while (p < line_len && line_ids[head + IDX_W'(p)] != r.task_id) p++;
          if (p < line_len) begin
            for (int q = p; q + 1 < line_len; q++) begin
              line_ids[head + IDX_W'(q)] = line_ids[head + IDX_W'(q + 1)];
            end
            line_len = line_len - 1;
            st = ST_OK;
          end
          queued_mark[r.task_id] = 1'b0;
        end
      end
      REQ_REINIT: begin
        while (line_len > 0) woken.push_back(take_oldest());
        units = (load_count > count_limit) ? count_limit : load_count;
        shut = 1'b0;
        head = '0;
        st = ST_OK;
      end
      default: st = ST_UNAVAIL;
    endcase
    n = woken.size();
    for (int i = 0; i <= n; i++) begin
      item.result_kind = (i < n) ? KIND_WAKE : KIND_REPLY;
      item.task_id_out = (i < n) ? woken[i] : r.task_id;
      item.status      = (i < n) ? ST_OK : st;
      item.count_now   = units;
      item.waiters_now = 5'(line_len);
      item.last        = (i == n);
      awaited_results.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && req_ready) begin
        step_semaphore(req);
        accepted_total++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t exp;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          flag($sformatf({"unexpected result: kind=%0d id=%0d status=%0d count=%0d ",
                          "waiters=%0d last=%0d"},
                         rsp.result_kind, rsp.task_id_out, rsp.status, rsp.count_now,
                         rsp.waiters_now, rsp.last));
        end else begin
          exp = awaited_results.pop_front();
          if (rsp.result_kind !== exp.result_kind || rsp.task_id_out !== exp.task_id_out ||
              rsp.status !== exp.status || rsp.count_now !== exp.count_now ||
              rsp.waiters_now !== exp.waiters_now || rsp.last !== exp.last) begin
            flag($sformatf({"result mismatch: expected kind=%0d id=%0d status=%0d count=%0d ",
                            "waiters=%0d last=%0d, got kind=%0d id=%0d status=%0d count=%0d ",
                            "waiters=%0d last=%0d"},
                           exp.result_kind, exp.task_id_out, exp.status, exp.count_now,
                           exp.waiters_now, exp.last, rsp.result_kind, rsp.task_id_out,
                           rsp.status, rsp.count_now, rsp.waiters_now, rsp.last));
          end
        end
      end
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic push_req(input logic [2:0] kind, input logic [ID_W-1:0] id);
    req_t r;
    r.req_type = kind;
    r.task_id = id;
    pending_reqs.push_back(r);
    queued_total++;
    if (kind <= REQ_REINIT) real_items++;
  endtask

  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {1'($urandom_range(0, 1)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_INIT) load_count = value;
    else count_limit = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_W-1:0] !== value) begin
      flag($sformatf("register %0d read back %0d, expected %0d", idx, prdata[CNT_W-1:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (accepted_total != queued_total || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_requests(input int n);
    logic [ID_W-1:0] ids [MAX_TASKS];
    logic [ID_W-1:0] t;
    int              target;
    int              pick;
    int              len;
    int              j;
    target = real_items + n;
    while (real_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        for (int i = 0; i < MAX_TASKS; i++) ids[i] = ID_W'(i);
        for (int i = MAX_TASKS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = ids[i];
          ids[i] = ids[j];
          ids[j] = t;
        end
        len = $urandom_range(2, MAX_TASKS);
        for (int i = 0; i < len; i++) push_req(REQ_WAIT, ids[i]);
      end else if (pick < 42) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          push_req(REQ_POST, ID_W'($urandom));
          if ($urandom_range(0, 1)) push_req(REQ_WAIT, ID_W'($urandom));
        end
      end else if (pick < 57) begin
        len = $urandom_range(1, 2);
        for (int i = 0; i < len; i++) push_req(REQ_CANCEL, ID_W'($urandom));
      end else if (pick < 65) begin
        push_req(REQ_TRYWAIT, ID_W'($urandom));
      end else if (pick < 71) begin
        push_req(REQ_CLOSE, ID_W'($urandom));
      end else if (pick < 78) begin
        push_req(REQ_REINIT, ID_W'($urandom));
      end else if (pick < 83) begin
        push_req(3'($urandom_range(6, 7)), ID_W'($urandom));
      end else begin
        push_req(REQ_WAIT, ID_W'($urandom));
      end
    end
  endtask

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    push_req(REQ_WAIT, 4'd0);
    push_req(REQ_WAIT, 4'd0);
    push_req(REQ_WAIT, 4'd15);
    push_req(REQ_TRYWAIT, 4'd9);
    push_req(REQ_CANCEL, 4'd3);
    push_req(REQ_CANCEL, 4'd0);
    push_req(REQ_WAIT, 4'd10);
    push_req(REQ_WAIT, 4'd5);
    push_req(REQ_CANCEL, 4'd10);
    push_req(REQ_POST, 4'd2);
    push_req(REQ_WAIT, 4'd5);
    push_req(REQ_POST, 4'd1);
    push_req(REQ_WAIT, 4'd3);
    push_req(REQ_CLOSE, 4'd0);
    push_req(REQ_WAIT, 4'd4);
    push_req(REQ_TRYWAIT, 4'd4);
    push_req(REQ_POST, 4'd4);
    push_req(REQ_CLOSE, 4'd8);
    push_req(REQ_CANCEL, 4'd4);
    push_req(3'd6, 4'd11);
    push_req(3'd7, 4'd14);
    push_req(REQ_REINIT, 4'd12);
    settle();

    write_reg(REG_INIT, CNT_TOP);
    write_reg(REG_MAX, CNT_TOP);
    push_req(REQ_REINIT, 4'd7);
    push_req(REQ_POST, 4'd7);
    push_req(REQ_TRYWAIT, 4'd7);
    push_req(REQ_POST, 4'd7);
    settle();

    write_reg(REG_INIT, 31'd9);
    write_reg(REG_MAX, 31'd4);
    push_req(REQ_REINIT, 4'd2);
    push_req(REQ_POST, 4'd2);
    settle();

    write_reg(REG_MAX, '0);
    write_reg(REG_INIT, '0);
    push_req(REQ_REINIT, 4'd6);
    push_req(REQ_POST, 4'd6);
    push_req(REQ_WAIT, 4'd6);
    push_req(REQ_REINIT, 4'd9);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_INIT, 31'($urandom_range(0, 3)));
          write_reg(REG_MAX, CNT_TOP);
        end
        1: begin
          write_reg(REG_INIT, 31'($urandom_range(0, 2)));
          write_reg(REG_MAX, 31'($urandom_range(1, 4)));
          steady = 1'b1;
        end
        2: begin
          write_reg(REG_INIT, '0);
          write_reg(REG_MAX, 31'($urandom_range(1, 3)));
        end
        default: begin
          write_reg(REG_INIT, 31'($urandom_range(0, 2)));
          write_reg(REG_MAX, 31'($urandom_range(0, 2)));
        end
      endcase
      push_req(REQ_REINIT, ID_W'($urandom));
      random_requests(30);
      settle();
      steady = 1'b0;
    end

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
